// ===== design/sppl_pkg.sv =====
// ----------------------------------------------------------------------------
// sppl_pkg
// Shared types and codes for the sprite pixel placer: command and status
// codes, register map, descriptor/pen item and result records.
// ----------------------------------------------------------------------------
package sppl_pkg;

	// fixed widths of the channel fields
	localparam int unsigned REG_W     = 10;
	localparam int unsigned COORD_W   = 10;
	localparam int unsigned FETCH_W   = 20;
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned PDATA_W   = 32;
	localparam int unsigned POS_W     = 18;
	localparam int unsigned TILE_SH   = 7;

	// clip window after reset
	localparam logic [REG_W-1:0] CLIP_LEFT_RST   = 10'd0;
	localparam logic [REG_W-1:0] CLIP_RIGHT_RST  = 10'd335;
	localparam logic [REG_W-1:0] CLIP_TOP_RST    = 10'd16;
	localparam logic [REG_W-1:0] CLIP_BOTTOM_RST = 10'd255;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_PEN  = 1'b1
	} command_e;

	typedef enum logic [1:0] {
		STATUS_PEN       = 2'd0,
		STATUS_LOADED    = 2'd1,
		STATUS_DISCARDED = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_RIGHT  = 2'd1,
		REG_CLIP_TOP    = 2'd2,
		REG_CLIP_BOTTOM = 2'd3
	} reg_index_e;

	typedef struct packed {
		logic [REG_W-1:0] left;
		logic [REG_W-1:0] right;
		logic [REG_W-1:0] top;
		logic [REG_W-1:0] bottom;
	} clip_cfg_t;

	typedef struct packed {
		command_e           command;
		logic signed [15:0] group_x;
		logic signed [15:0] group_y;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic [15:0]        tile_number;
		logic [15:0]        attribute_word;
		logic [15:0]        size_word;
		logic [7:0]         pen_value;
	} item_t;

	typedef struct packed {
		logic               write_enable;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [15:0]        color_index;
		logic [FETCH_W-1:0] fetch_address;
		logic               last_pixel;
		status_e            status;
	} result_t;

endpackage

// ===== design/sppl_in_if.sv =====
// ----------------------------------------------------------------------------
// sppl_in_if
// Input channel: descriptor loads and pen bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sppl_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] group_x;
	logic signed [15:0] group_y;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic [15:0]        tile_number;
	logic [15:0]        attribute_word;
	logic [15:0]        size_word;
	logic [7:0]         pen_value;

	modport source (
		output valid, command, group_x, group_y, offset_x, offset_y,
		       tile_number, attribute_word, size_word, pen_value,
		input  ready
	);

	modport sink (
		input  valid, command, group_x, group_y, offset_x, offset_y,
		       tile_number, attribute_word, size_word, pen_value,
		output ready
	);
endinterface

// ===== design/sppl_out_if.sv =====
// ----------------------------------------------------------------------------
// sppl_out_if
// Result channel: placed pixel, fetch address and status, valid/ready.
// ----------------------------------------------------------------------------
interface sppl_out_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [15:0] color_index;
	logic [19:0] fetch_address;
	logic        last_pixel;
	logic [1:0]  status;

	modport source (
		output valid, write_enable, pixel_x, pixel_y, color_index,
		       fetch_address, last_pixel, status,
		input  ready
	);

	modport sink (
		input  valid, write_enable, pixel_x, pixel_y, color_index,
		       fetch_address, last_pixel, status,
		output ready
	);
endinterface

// ===== design/sprite_pixel_placer_core.sv =====
// An accepted item's result is held in the output register from the cycle after it is accepted.
// Throughput: one item per cycle; a new item is taken whenever the output register
// is empty or its result is taken in the same cycle.
// Per-pen work is a counter step plus small multiplies, adds and clip compares in one pass.
// Reset (arst_n low): no sprite active, counters and address cleared, clip window
// set to x 0..335, y 16..255, output register empty.
// ----------------------------------------------------------------------------
// sprite_pixel_placer_core
// Places the pens of one sprite on screen: descriptor load, four nested cell
// counters, flips, clipping and fetch address generation.
// ----------------------------------------------------------------------------
module sprite_pixel_placer_core
	import sppl_pkg::*;
#(
	parameter int unsigned ADDRESS_BITS = 20,
	parameter int unsigned COORD_BITS   = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	sppl_in_if.sink            item,
	sppl_out_if.source         result
);

	clip_cfg_t clip;
	item_t     item_d;
	result_t   res;
	result_t   result_s1;
	logic      valid_s1;
	logic      accept;

	sppl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clip    (clip)
	);

	// pack the input channel
	always_comb begin
		item_d.command        = command_e'(item.command);
		item_d.group_x        = item.group_x;
		item_d.group_y        = item.group_y;
		item_d.offset_x       = item.offset_x;
		item_d.offset_y       = item.offset_y;
		item_d.tile_number    = item.tile_number;
		item_d.attribute_word = item.attribute_word;
		item_d.size_word      = item.size_word;
		item_d.pen_value      = item.pen_value;
	end

	sppl_sprite_engine #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.COORD_BITS   (COORD_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item_d (item_d),
		.clip   (clip),
		.res    (res)
	);

	// handshake: take an item whenever the output register frees up
	assign item.ready = !valid_s1 || result.ready;
	assign accept     = item.valid && item.ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (result.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= res;
		end
	end

	assign result.valid         = valid_s1;
	assign result.write_enable  = result_s1.write_enable;
	assign result.pixel_x       = result_s1.pixel_x;
	assign result.pixel_y       = result_s1.pixel_y;
	assign result.color_index   = result_s1.color_index;
	assign result.fetch_address = result_s1.fetch_address;
	assign result.last_pixel    = result_s1.last_pixel;
	assign result.status        = result_s1.status;

	// every accepted transaction shows up in the output register
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction did not reach output register");

	// an empty output register never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stalled with empty output register");

	// a held result is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !result.ready |-> !accept)
		else $error("input accepted while result is stalled");

endmodule

// ===== design/sppl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sppl_cfg_regs
// APB register file for the clip window. Four 10-bit registers at byte
// addresses 0, 4, 8 and 12; zero wait states.
// ----------------------------------------------------------------------------
module sppl_cfg_regs
	import sppl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output clip_cfg_t          clip
);

	reg_index_e reg_sel;
	logic       wr_en;
	clip_cfg_t  clip_q;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_e'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign clip    = clip_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= CLIP_LEFT_RST;
			clip_q.right  <= CLIP_RIGHT_RST;
			clip_q.top    <= CLIP_TOP_RST;
			clip_q.bottom <= CLIP_BOTTOM_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CLIP_LEFT:   clip_q.left   <= pwdata[REG_W-1:0];
				REG_CLIP_RIGHT:  clip_q.right  <= pwdata[REG_W-1:0];
				REG_CLIP_TOP:    clip_q.top    <= pwdata[REG_W-1:0];
				REG_CLIP_BOTTOM: clip_q.bottom <= pwdata[REG_W-1:0];
				default:         clip_q        <= clip_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_CLIP_LEFT:   prdata[REG_W-1:0] = clip_q.left;
			REG_CLIP_RIGHT:  prdata[REG_W-1:0] = clip_q.right;
			REG_CLIP_TOP:    prdata[REG_W-1:0] = clip_q.top;
			REG_CLIP_BOTTOM: prdata[REG_W-1:0] = clip_q.bottom;
			default:         prdata            = '0;
		endcase
	end

endmodule

// ===== design/sppl_sprite_engine.sv =====
// ----------------------------------------------------------------------------
// sppl_sprite_engine
// Sprite state (origin, cell geometry, counters, flips, bank, pen address)
// and the single-pass logic that turns one item into one result.
// ----------------------------------------------------------------------------
module sppl_sprite_engine
	import sppl_pkg::*;
#(
	parameter int unsigned ADDRESS_BITS = 20,
	parameter int unsigned COORD_BITS   = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  item_t     item_d,
	input  clip_cfg_t clip,
	output result_t   res
);

	localparam int unsigned TILE_ADDR_W = 16 + TILE_SH;
	localparam int unsigned AEXT_W  = (ADDRESS_BITS > TILE_ADDR_W) ? ADDRESS_BITS : TILE_ADDR_W;
	localparam int unsigned FEXT_W  = (ADDRESS_BITS > FETCH_W) ? ADDRESS_BITS : FETCH_W;
	localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

	// sprite state
	logic signed [POS_W-1:0]  origin_x_q, origin_y_q;
	logic [3:0]               cols_m1_q, rows_m1_q, sx_q, sy_q;
	logic [3:0]               cx_q, cy_q, ry_q, rx_q;
	logic                     hflip_q, upright_q;
	logic [7:0]               bank_q;
	logic [ADDRESS_BITS-1:0]  pen_address_q;
	logic                     active_q;

	// descriptor decode
	logic signed [POS_W-1:0]  gx_e, gy_e, ox_e, oy_e;
	logic signed [POS_W-1:0]  load_origin_x, load_origin_y;
	logic [4:0]               rows_p1, height_p1;
	logic [9:0]               span_prod, span;
	logic [15:0]              tile_masked;
	logic [TILE_ADDR_W-1:0]   tile_addr;
	logic [AEXT_W-1:0]        tile_addr_ext;
	logic [ADDRESS_BITS-1:0]  load_address;

	// pen placement
	logic [4:0]               sx_p1, sy_p1;
	logic [3:0]               col_sel, rx_sel, row_sel;
	logic [8:0]               col_off, row_off;
	logic signed [POS_W-1:0]  px, py;
	logic                     in_clip, last;
	logic [ADDRESS_BITS-1:0]  next_address;
	logic [3:0]               cx_n, cy_n, ry_n, rx_n;
	logic [FEXT_W-1:0]        fetch_ext;
	logic                     is_load, is_pen;

	assign is_load = (item_d.command == CMD_LOAD);
	assign is_pen  = (item_d.command == CMD_PEN) && active_q;

	// origin and first address of a new sprite
	always_comb begin
		gx_e = {{(POS_W-16){item_d.group_x[15]}},  item_d.group_x};
		gy_e = {{(POS_W-16){item_d.group_y[15]}},  item_d.group_y};
		ox_e = {{(POS_W-16){item_d.offset_x[15]}}, item_d.offset_x};
		oy_e = {{(POS_W-16){item_d.offset_y[15]}}, item_d.offset_y};
		rows_p1   = {1'b0, item_d.size_word[15:12]} + 5'd1;
		height_p1 = {1'b0, item_d.size_word[11:8]} + 5'd1;
		span_prod = {5'b0, rows_p1} * {5'b0, height_p1};
		span      = span_prod - 10'd1;
		load_origin_x = gx_e + ox_e;
		load_origin_y = gy_e + oy_e - $signed({{(POS_W-10){1'b0}}, span});
		tile_masked   = item_d.tile_number & ~{13'b0, item_d.size_word[13:11]};
		tile_addr     = {tile_masked, {TILE_SH{1'b0}}};
		tile_addr_ext = AEXT_W'(tile_addr);
		load_address  = tile_addr_ext[ADDRESS_BITS-1:0];
	end

	// screen position, clip test and end-of-sprite detect
	always_comb begin
		sx_p1   = {1'b0, sx_q} + 5'd1;
		sy_p1   = {1'b0, sy_q} + 5'd1;
		col_sel = hflip_q ? (cols_m1_q - cx_q) : cx_q;
		rx_sel  = hflip_q ? (sx_q - rx_q) : rx_q;
		row_sel = upright_q ? ry_q : (sy_q - ry_q);
		col_off = {5'b0, col_sel} * {4'b0, sx_p1};
		row_off = {5'b0, cy_q} * {4'b0, sy_p1};
		px = origin_x_q + $signed({{(POS_W-9){1'b0}}, col_off})
		                + $signed({{(POS_W-4){1'b0}}, rx_sel});
		py = origin_y_q + $signed({{(POS_W-9){1'b0}}, row_off})
		                + $signed({{(POS_W-4){1'b0}}, row_sel});
		in_clip = (px >= $signed({{(POS_W-REG_W){1'b0}}, clip.left}))
		       && (px <= $signed({{(POS_W-REG_W){1'b0}}, clip.right}))
		       && (py >= $signed({{(POS_W-REG_W){1'b0}}, clip.top}))
		       && (py <= $signed({{(POS_W-REG_W){1'b0}}, clip.bottom}));
		last = (cx_q == cols_m1_q) && (cy_q == rows_m1_q)
		    && (ry_q == sy_q) && (rx_q == sx_q);
		next_address = pen_address_q + ADDRESS_BITS'(1);
	end

	// counter step: column in cell, row in cell, row of cells, column of cells
	always_comb begin
		cx_n = cx_q;
		cy_n = cy_q;
		ry_n = ry_q;
		rx_n = rx_q;
		if (rx_q < sx_q) begin
			rx_n = rx_q + 4'd1;
		end else begin
			rx_n = 4'd0;
			if (ry_q < sy_q) begin
				ry_n = ry_q + 4'd1;
			end else begin
				ry_n = 4'd0;
				if (cy_q < rows_m1_q) begin
					cy_n = cy_q + 4'd1;
				end else begin
					cy_n = 4'd0;
					cx_n = cx_q + 4'd1;
				end
			end
		end
		if (last) begin
			cx_n = 4'd0;
			cy_n = 4'd0;
			ry_n = 4'd0;
			rx_n = 4'd0;
		end
	end

	// result record
	always_comb begin
		res = '0;
		if (is_load) begin
			fetch_ext         = FEXT_W'(load_address);
			res.fetch_address = fetch_ext[FETCH_W-1:0];
			res.status        = STATUS_LOADED;
		end else if (is_pen) begin
			fetch_ext         = FEXT_W'(next_address);
			res.write_enable  = (item_d.pen_value != 8'd0) && in_clip;
			res.pixel_x       = px[COORD_W-1:0] & COORD_MASK;
			res.pixel_y       = py[COORD_W-1:0] & COORD_MASK;
			res.color_index   = {bank_q, item_d.pen_value};
			res.fetch_address = fetch_ext[FETCH_W-1:0];
			res.last_pixel    = last;
			res.status        = STATUS_PEN;
		end else begin
			fetch_ext         = FEXT_W'(pen_address_q);
			res.fetch_address = fetch_ext[FETCH_W-1:0];
			res.status        = STATUS_DISCARDED;
		end
	end

	// state update per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			cols_m1_q     <= '0;
			rows_m1_q     <= '0;
			sx_q          <= '0;
			sy_q          <= '0;
			cx_q          <= '0;
			cy_q          <= '0;
			ry_q          <= '0;
			rx_q          <= '0;
			hflip_q       <= 1'b0;
			upright_q     <= 1'b0;
			bank_q        <= '0;
			pen_address_q <= '0;
			active_q      <= 1'b0;
		end else if (accept && is_load) begin
			origin_x_q    <= load_origin_x;
			origin_y_q    <= load_origin_y;
			cols_m1_q     <= item_d.size_word[7:4];
			rows_m1_q     <= item_d.size_word[15:12];
			sx_q          <= item_d.size_word[3:0];
			sy_q          <= item_d.size_word[11:8];
			cx_q          <= '0;
			cy_q          <= '0;
			ry_q          <= '0;
			rx_q          <= '0;
			hflip_q       <= item_d.attribute_word[15];
			upright_q     <= item_d.attribute_word[14];
			bank_q        <= item_d.attribute_word[7:0];
			pen_address_q <= load_address;
			active_q      <= 1'b1;
		end else if (accept && is_pen) begin
			cx_q          <= cx_n;
			cy_q          <= cy_n;
			ry_q          <= ry_n;
			rx_q          <= rx_n;
			pen_address_q <= next_address;
			active_q      <= !last;
		end
	end

	// final pen ends the sprite
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_pen && last |=> !active_q && cx_q == 4'd0 && rx_q == 4'd0)
		else $error("sprite still active after final pen");

	// discarded pen leaves the address alone
	a_discard_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_load && !is_pen |=> $stable(pen_address_q) && !active_q)
		else $error("discarded pen changed sprite state");

	// load arms the sprite with cleared counters
	a_load_arms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_load |=> active_q && cy_q == 4'd0 && ry_q == 4'd0)
		else $error("load did not arm sprite");

endmodule
